### rtl/core/pmti_pkg.sv
// shared constants, types and helpers of the poisson mixture table interpolator
package pmti_pkg;

  // table geometry
  localparam int NUM_LEVELS    = 12;
  localparam int TABLE_COLUMNS = 1024;
  localparam int HALF_COLUMNS  = (TABLE_COLUMNS + 1) / 2;
  localparam int BANK_DEPTH    = NUM_LEVELS * HALF_COLUMNS;
  localparam int ADDR_W        = $clog2(BANK_DEPTH);
  localparam int ROW_W         = $clog2(NUM_LEVELS);
  localparam int COL_W         = $clog2(TABLE_COLUMNS);

  // word field widths
  localparam int OP_W       = 1;
  localparam int TROW_W     = 4;
  localparam int TCOL_W     = 10;
  localparam int CDF_W      = 17;
  localparam int INT_W      = 24;
  localparam int INTENS_W   = 32;
  localparam int ACT_W      = 20;
  localparam int GEN_W      = 28;
  localparam int WORD_W     = CDF_W + INT_W;

  // register widths and reset values
  localparam int AMP_W      = 21;
  localparam int ISTEP_W    = 16;
  localparam int SCALE_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = AMP_W;
  localparam logic [AMP_W-1:0]   AMP_RST   = AMP_W'(65536);
  localparam logic [ISTEP_W-1:0] ISTEP_RST = ISTEP_W'(5120);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(65536);

  // fixed point layout
  localparam int FRAC_W    = 16;
  localparam int WGT_W     = 20;
  localparam int CW_W      = FRAC_W + 1;
  localparam int X_W       = INTENS_W + ISTEP_W;
  localparam int XCOL_LSB  = 24;
  localparam int XCOL_W    = X_W - XCOL_LSB;
  localparam int RES_SHIFT = 3 * FRAC_W;
  localparam logic [ACT_W-1:0] ACT_MAX = '1;
  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMPLITUDE     = 2'd0,
    CFG_INVERSE_STEP  = 2'd1,
    CFG_MIXTURE_SCALE = 2'd2
  } cfg_reg_t;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  // row bases and mixture weights derived from the registers
  typedef struct packed {
    addr_t              base_lo;
    addr_t              base_hi;
    logic [WGT_W-1:0]   w_lo;
    logic [WGT_W-1:0]   w_hi;
  } row_cfg_t;

  // sideband that travels with the table read
  typedef struct packed {
    logic              query;
    logic [FRAC_W-1:0] frac;
    logic              l_odd;
    logic              r_odd;
  } mac_ctl_t;

  typedef struct packed {
    logic             push;
    logic [ACT_W-1:0] active;
    logic [GEN_W-1:0] generated;
  } mac_res_t;

  // first bank address of a row (one bank holds every other column)
  function automatic addr_t row_base(input addr_t row);
    row_base = row * addr_t'(HALF_COLUMNS);
  endfunction

endpackage

### rtl/core/pmti_ram.sv
// generic ram, one write port and two registered read ports
module pmti_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DATA_W-1:0]        rdata_a,
  output logic [DATA_W-1:0]        rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_a_r;
  logic [DATA_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

### rtl/core/pmti_rowsel.sv
// mixture row selection and scaled row weights from the amplitude and mixture scale registers
module pmti_rowsel (
  input  logic                         clk,
  input  logic [pmti_pkg::AMP_W-1:0]   amplitude,
  input  logic [pmti_pkg::SCALE_W-1:0] scale,
  output pmti_pkg::row_cfg_t           row_cfg
);

  localparam int A_W    = pmti_pkg::AMP_W + 1;
  localparam int N_W    = A_W - pmti_pkg::FRAC_W;
  localparam int RAW_W  = pmti_pkg::FRAC_W + 1;
  localparam int PROD_W = RAW_W + pmti_pkg::SCALE_W;
  localparam logic [A_W-1:0]   A_TOP = A_W'(pmti_pkg::NUM_LEVELS * (1 << pmti_pkg::FRAC_W));
  localparam logic [RAW_W-1:0] ONE   = RAW_W'(1 << pmti_pkg::FRAC_W);

  logic [A_W-1:0]               a_cl;
  logic [N_W-1:0]               n;
  logic [pmti_pkg::FRAC_W-1:0]  f;
  logic [RAW_W-1:0]             raw_lo;
  logic [RAW_W-1:0]             raw_hi;
  logic [pmti_pkg::ROW_W-1:0]   row_lo;
  logic [pmti_pkg::ROW_W-1:0]   row_hi;
  logic [PROD_W-1:0]            prod_lo;
  logic [PROD_W-1:0]            prod_hi;
  pmti_pkg::row_cfg_t           row_cfg_nxt;
  pmti_pkg::row_cfg_t           row_cfg_r;

  always_comb begin
    a_cl   = ({1'b0, amplitude} > A_TOP) ? A_TOP : {1'b0, amplitude};
    n      = a_cl[A_W-1:pmti_pkg::FRAC_W];
    f      = a_cl[pmti_pkg::FRAC_W-1:0];
    raw_lo = ONE - {1'b0, f};
    raw_hi = {1'b0, f};
    row_lo = pmti_pkg::ROW_W'(n - N_W'(1));
    row_hi = pmti_pkg::ROW_W'(n);
    // below one level only row 0 carries weight
    if (n == '0) begin
      row_lo = '0;
      row_hi = '0;
      raw_lo = '0;
    end
    // at the top the full weight moves onto the last row
    if (n == N_W'(pmti_pkg::NUM_LEVELS)) begin
      row_hi = row_lo;
      raw_hi = raw_lo;
      raw_lo = '0;
    end
    prod_lo = PROD_W'(raw_lo) * PROD_W'(scale);
    prod_hi = PROD_W'(raw_hi) * PROD_W'(scale);
    row_cfg_nxt.base_lo = pmti_pkg::row_base(pmti_pkg::ADDR_W'(row_lo));
    row_cfg_nxt.base_hi = pmti_pkg::row_base(pmti_pkg::ADDR_W'(row_hi));
    row_cfg_nxt.w_lo    = prod_lo[pmti_pkg::FRAC_W +: pmti_pkg::WGT_W];
    row_cfg_nxt.w_hi    = prod_hi[pmti_pkg::FRAC_W +: pmti_pkg::WGT_W];
  end

  always_ff @(posedge clk) begin
    row_cfg_r <= row_cfg_nxt;
  end

  assign row_cfg = row_cfg_r;

endmodule

### rtl/core/pmti_mac.sv
// bilinear weighting pipeline: row products, row sums, column products, saturation
module pmti_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pmti_pkg::mac_ctl_t         ctl,
  input  logic [pmti_pkg::WGT_W-1:0] w_lo,
  input  logic [pmti_pkg::WGT_W-1:0] w_hi,
  input  pmti_pkg::word_t            even_lo,
  input  pmti_pkg::word_t            even_hi,
  input  pmti_pkg::word_t            odd_lo,
  input  pmti_pkg::word_t            odd_hi,
  output pmti_pkg::mac_res_t         res
);

  localparam int SPLIT_W = 24;
  localparam int CP_W    = pmti_pkg::WGT_W + pmti_pkg::CDF_W;
  localparam int CS_W    = CP_W + 1;
  localparam int IP_W    = pmti_pkg::WGT_W + pmti_pkg::INT_W;
  localparam int IS_W    = IP_W + 1;
  localparam int CH_W    = CS_W - SPLIT_W;
  localparam int IH_W    = IS_W - SPLIT_W;
  localparam int PPL_W   = pmti_pkg::CW_W + SPLIT_W;
  localparam int CPH_W   = pmti_pkg::CW_W + CH_W;
  localparam int IPH_W   = pmti_pkg::CW_W + IH_W;
  localparam int SL_W    = PPL_W + 1;
  localparam int CSH_W   = CPH_W + 1;
  localparam int ISH_W   = IPH_W + 1;
  localparam int TOT_W   = pmti_pkg::RES_SHIFT + pmti_pkg::GEN_W;
  localparam int CDF_LSB = pmti_pkg::INT_W;

  // stage 3 operand select: left/right column from the even/odd bank
  pmti_pkg::word_t wd_ll;
  pmti_pkg::word_t wd_hl;
  pmti_pkg::word_t wd_lr;
  pmti_pkg::word_t wd_hr;

  logic                            q3_r, q4_r, q5_r, q6_r;
  logic [pmti_pkg::FRAC_W-1:0]     d3_r, d4_r;
  logic [CP_W-1:0]                 c_ll_r, c_hl_r, c_lr_r, c_hr_r;
  logic [IP_W-1:0]                 i_ll_r, i_hl_r, i_lr_r, i_hr_r;
  logic [CS_W-1:0]                 cs_l_r, cs_r_r;
  logic [IS_W-1:0]                 is_l_r, is_r_r;
  logic [pmti_pkg::CW_W-1:0]       dc5;
  logic [pmti_pkg::CW_W-1:0]       dw5;
  logic [PPL_W-1:0]                cl_lo_r, cr_lo_r, il_lo_r, ir_lo_r;
  logic [CPH_W-1:0]                cl_hi_r, cr_hi_r;
  logic [IPH_W-1:0]                il_hi_r, ir_hi_r;
  logic [SL_W-1:0]                 c_lo_r, i_lo_r;
  logic [CSH_W-1:0]                c_hi_r;
  logic [ISH_W-1:0]                i_hi_r;
  logic [TOT_W-1:0]                c_tot, i_tot;
  logic [pmti_pkg::ACT_W-1:0]      act_sat;
  logic [pmti_pkg::GEN_W-1:0]      gen_sat;

  assign wd_ll = ctl.l_odd ? odd_lo : even_lo;
  assign wd_hl = ctl.l_odd ? odd_hi : even_hi;
  assign wd_lr = ctl.r_odd ? odd_lo : even_lo;
  assign wd_hr = ctl.r_odd ? odd_hi : even_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q3_r <= 1'b0;
      q4_r <= 1'b0;
      q5_r <= 1'b0;
      q6_r <= 1'b0;
    end else begin
      q3_r <= ctl.query;
      q4_r <= q3_r;
      q5_r <= q4_r;
      q6_r <= q5_r;
    end
  end

  // stage 3: row weight times table value
  always_ff @(posedge clk) begin
    d3_r   <= ctl.frac;
    c_ll_r <= CP_W'(w_lo) * CP_W'(wd_ll[CDF_LSB +: pmti_pkg::CDF_W]);
    c_hl_r <= CP_W'(w_hi) * CP_W'(wd_hl[CDF_LSB +: pmti_pkg::CDF_W]);
    c_lr_r <= CP_W'(w_lo) * CP_W'(wd_lr[CDF_LSB +: pmti_pkg::CDF_W]);
    c_hr_r <= CP_W'(w_hi) * CP_W'(wd_hr[CDF_LSB +: pmti_pkg::CDF_W]);
    i_ll_r <= IP_W'(w_lo) * IP_W'(wd_ll[pmti_pkg::INT_W-1:0]);
    i_hl_r <= IP_W'(w_hi) * IP_W'(wd_hl[pmti_pkg::INT_W-1:0]);
    i_lr_r <= IP_W'(w_lo) * IP_W'(wd_lr[pmti_pkg::INT_W-1:0]);
    i_hr_r <= IP_W'(w_hi) * IP_W'(wd_hr[pmti_pkg::INT_W-1:0]);
  end

  // stage 4: mix the two rows per column
  always_ff @(posedge clk) begin
    d4_r   <= d3_r;
    cs_l_r <= CS_W'(c_ll_r) + CS_W'(c_hl_r);
    cs_r_r <= CS_W'(c_lr_r) + CS_W'(c_hr_r);
    is_l_r <= IS_W'(i_ll_r) + IS_W'(i_hl_r);
    is_r_r <= IS_W'(i_lr_r) + IS_W'(i_hr_r);
  end

  // stage 5: column weights, row sums cut into low and high halves
  assign dc5 = pmti_pkg::CW_W'(1 << pmti_pkg::FRAC_W) - pmti_pkg::CW_W'(d4_r);
  assign dw5 = pmti_pkg::CW_W'(d4_r);

  always_ff @(posedge clk) begin
    cl_lo_r <= PPL_W'(dc5) * PPL_W'(cs_l_r[SPLIT_W-1:0]);
    cr_lo_r <= PPL_W'(dw5) * PPL_W'(cs_r_r[SPLIT_W-1:0]);
    cl_hi_r <= CPH_W'(dc5) * CPH_W'(cs_l_r[CS_W-1:SPLIT_W]);
    cr_hi_r <= CPH_W'(dw5) * CPH_W'(cs_r_r[CS_W-1:SPLIT_W]);
    il_lo_r <= PPL_W'(dc5) * PPL_W'(is_l_r[SPLIT_W-1:0]);
    ir_lo_r <= PPL_W'(dw5) * PPL_W'(is_r_r[SPLIT_W-1:0]);
    il_hi_r <= IPH_W'(dc5) * IPH_W'(is_l_r[IS_W-1:SPLIT_W]);
    ir_hi_r <= IPH_W'(dw5) * IPH_W'(is_r_r[IS_W-1:SPLIT_W]);
  end

  // stage 6: add the columns
  always_ff @(posedge clk) begin
    c_lo_r <= SL_W'(cl_lo_r) + SL_W'(cr_lo_r);
    c_hi_r <= CSH_W'(cl_hi_r) + CSH_W'(cr_hi_r);
    i_lo_r <= SL_W'(il_lo_r) + SL_W'(ir_lo_r);
    i_hi_r <= ISH_W'(il_hi_r) + ISH_W'(ir_hi_r);
  end

  // stage 7: join halves, drop the fraction, saturate
  always_comb begin
    c_tot = (TOT_W'(c_hi_r) << SPLIT_W) + TOT_W'(c_lo_r);
    i_tot = (TOT_W'(i_hi_r) << SPLIT_W) + TOT_W'(i_lo_r);
    act_sat = ((c_tot >> pmti_pkg::RES_SHIFT) > TOT_W'(pmti_pkg::ACT_MAX)) ?
              pmti_pkg::ACT_MAX : c_tot[pmti_pkg::RES_SHIFT +: pmti_pkg::ACT_W];
    gen_sat = ((i_tot >> pmti_pkg::RES_SHIFT) > TOT_W'(pmti_pkg::GEN_MAX)) ?
              pmti_pkg::GEN_MAX : i_tot[pmti_pkg::RES_SHIFT +: pmti_pkg::GEN_W];
  end

  assign res = '{push: q6_r, active: act_sat, generated: gen_sat};

endmodule

### rtl/core/poisson_mixture_table_interpolator.sv
// top level: config registers, load/query front end, banked tables, result queue
//
// Takes one word per clock while in_stall is low, loads and queries mixed in any
// order. A load writes one entry of both tables (a row or column outside the table
// is dropped) and gives no result. Queries stream at one per cycle while in_stall
// is low. Both tables share one 41-bit word per entry and are split by column
// parity into an even and an odd bank, each a synchronous ram with one write port and
// two read ports (lower and upper mixture row), so the four corners of one query are
// read in a single cycle. Loads write the bank in the same pipeline stage in which
// queries read it, so a query always sees every load accepted before it, with no
// forwarding. Table contents are undefined until loaded; there is no clear pass after
// reset. Results collect in an 8-word queue; in_stall rises when 8 queries are
// outstanding, i.e. only after out_stall has held results back for a while. Row
// selection and mixture weights are recomputed from the registers every cycle and
// registered; registers are to be written only while no query is in flight.
module poisson_mixture_table_interpolator (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pmti_pkg::OP_W-1:0]       in_operation,
  input  logic [pmti_pkg::TROW_W-1:0]     in_table_row,
  input  logic [pmti_pkg::TCOL_W-1:0]     in_table_column,
  input  logic [pmti_pkg::CDF_W-1:0]      in_cdf_value,
  input  logic [pmti_pkg::INT_W-1:0]      in_integrated_value,
  input  logic [pmti_pkg::INTENS_W-1:0]   in_intensity,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pmti_pkg::ACT_W-1:0]      out_active_out,
  output logic [pmti_pkg::GEN_W-1:0]      out_generated_out,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pmti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmti_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [pmti_pkg::COL_W-1:0] LAST_COL =
    pmti_pkg::COL_W'(pmti_pkg::TABLE_COLUMNS - 1);
  localparam logic [pmti_pkg::FIFO_CNT_W-1:0] FIFO_FULL =
    pmti_pkg::FIFO_CNT_W'(pmti_pkg::FIFO_DEPTH);

  // config registers
  logic [pmti_pkg::AMP_W-1:0]   amp_r;
  logic [pmti_pkg::ISTEP_W-1:0] istep_r;
  logic [pmti_pkg::SCALE_W-1:0] scale_r;

  // front end handshake
  logic in_acc;
  logic q_acc;
  logic ld_ok;

  // stage 1
  logic                        q1_r;
  logic                        ld1_r;
  logic [pmti_pkg::X_W-1:0]    x_r;
  pmti_pkg::addr_t             ld_addr_r;
  logic                        ld_odd_r;
  pmti_pkg::word_t             ld_word_r;

  // column pick
  logic [pmti_pkg::XCOL_W-1:0] col_int;
  logic [pmti_pkg::COL_W-1:0]  col_l;
  logic [pmti_pkg::COL_W-1:0]  col_r;
  logic [pmti_pkg::COL_W-1:0]  even_col;
  logic [pmti_pkg::COL_W-1:0]  odd_col;
  pmti_pkg::addr_t             even_half;
  pmti_pkg::addr_t             odd_half;
  pmti_pkg::addr_t             rd_even_lo;
  pmti_pkg::addr_t             rd_even_hi;
  pmti_pkg::addr_t             rd_odd_lo;
  pmti_pkg::addr_t             rd_odd_hi;
  logic                        we_even;
  logic                        we_odd;

  // stage 2 sideband
  logic                        q2_r;
  logic [pmti_pkg::FRAC_W-1:0] d2_r;
  logic                        lodd2_r;
  logic                        rodd2_r;
  pmti_pkg::mac_ctl_t          ctl2;

  pmti_pkg::row_cfg_t          row_cfg;
  pmti_pkg::word_t             even_lo, even_hi, odd_lo, odd_hi;
  pmti_pkg::mac_res_t          res;

  // result queue
  logic [pmti_pkg::ACT_W-1:0]      act_q [pmti_pkg::FIFO_DEPTH];
  logic [pmti_pkg::GEN_W-1:0]      gen_q [pmti_pkg::FIFO_DEPTH];
  logic [pmti_pkg::FIFO_PTR_W-1:0] wr_ptr_r;
  logic [pmti_pkg::FIFO_PTR_W-1:0] rd_ptr_r;
  logic [pmti_pkg::FIFO_CNT_W-1:0] fcnt_r;
  logic [pmti_pkg::FIFO_CNT_W-1:0] fcnt_nxt;
  logic [pmti_pkg::FIFO_CNT_W-1:0] pend_r;
  logic [pmti_pkg::FIFO_CNT_W-1:0] pend_nxt;
  logic                            push;
  logic                            pop;

  // ---------------------------------------------------------------- config port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r   <= pmti_pkg::AMP_RST;
      istep_r <= pmti_pkg::ISTEP_RST;
      scale_r <= pmti_pkg::SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmti_pkg::CFG_AMPLITUDE:     amp_r   <= cfg_data[pmti_pkg::AMP_W-1:0];
        pmti_pkg::CFG_INVERSE_STEP:  istep_r <= cfg_data[pmti_pkg::ISTEP_W-1:0];
        pmti_pkg::CFG_MIXTURE_SCALE: scale_r <= cfg_data[pmti_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  pmti_rowsel u_rowsel (
    .clk       (clk),
    .amplitude (amp_r),
    .scale     (scale_r),
    .row_cfg   (row_cfg)
  );

  // ---------------------------------------------------------------- stage 1
  assign in_acc = in_valid && !in_stall;
  assign q_acc  = in_acc && (in_operation == pmti_pkg::OP_QUERY);
  // out-of-range loads are dropped here
  assign ld_ok  = (32'(in_table_row) < 32'(pmti_pkg::NUM_LEVELS)) &&
                  (32'(in_table_column) < 32'(pmti_pkg::TABLE_COLUMNS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_r  <= 1'b0;
      ld1_r <= 1'b0;
    end else begin
      q1_r  <= q_acc;
      ld1_r <= in_acc && (in_operation == pmti_pkg::OP_LOAD) && ld_ok;
    end
  end

  // intensity times inverse step gives column position in Q24.24
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r       <= pmti_pkg::X_W'(in_intensity) * pmti_pkg::X_W'(istep_r);
      ld_addr_r <= pmti_pkg::row_base(pmti_pkg::ADDR_W'(in_table_row)) +
                   pmti_pkg::ADDR_W'(in_table_column >> 1);
      ld_odd_r  <= in_table_column[0];
      ld_word_r <= {in_cdf_value, in_integrated_value};
    end
  end

  assign we_even = ld1_r && !ld_odd_r;
  assign we_odd  = ld1_r && ld_odd_r;

  // left and right columns, both clamped to the last column
  always_comb begin
    col_int = x_r[pmti_pkg::X_W-1:pmti_pkg::XCOL_LSB];
    if (col_int >= pmti_pkg::XCOL_W'(LAST_COL)) begin
      col_l = LAST_COL;
      col_r = LAST_COL;
    end else begin
      col_l = col_int[pmti_pkg::COL_W-1:0];
      col_r = col_l + pmti_pkg::COL_W'(1);
    end
    // adjacent columns land in different banks, except at the clamp where both are the last column
    even_col   = col_l[0] ? col_r : col_l;
    odd_col    = col_l[0] ? col_l : col_r;
    even_half  = pmti_pkg::ADDR_W'(even_col >> 1);
    odd_half   = pmti_pkg::ADDR_W'(odd_col >> 1);
    rd_even_lo = row_cfg.base_lo + even_half;
    rd_even_hi = row_cfg.base_hi + even_half;
    rd_odd_lo  = row_cfg.base_lo + odd_half;
    rd_odd_hi  = row_cfg.base_hi + odd_half;
  end

  pmti_ram #(
    .DATA_W (pmti_pkg::WORD_W),
    .DEPTH  (pmti_pkg::BANK_DEPTH)
  ) u_bank_even (
    .clk     (clk),
    .we      (we_even),
    .waddr   (ld_addr_r),
    .wdata   (ld_word_r),
    .raddr_a (rd_even_lo),
    .raddr_b (rd_even_hi),
    .rdata_a (even_lo),
    .rdata_b (even_hi)
  );

  pmti_ram #(
    .DATA_W (pmti_pkg::WORD_W),
    .DEPTH  (pmti_pkg::BANK_DEPTH)
  ) u_bank_odd (
    .clk     (clk),
    .we      (we_odd),
    .waddr   (ld_addr_r),
    .wdata   (ld_word_r),
    .raddr_a (rd_odd_lo),
    .raddr_b (rd_odd_hi),
    .rdata_a (odd_lo),
    .rdata_b (odd_hi)
  );

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q2_r <= 1'b0;
    end else begin
      q2_r <= q1_r;
    end
  end

  always_ff @(posedge clk) begin
    d2_r    <= x_r[pmti_pkg::XCOL_LSB-1 -: pmti_pkg::FRAC_W];
    lodd2_r <= col_l[0];
    rodd2_r <= col_r[0];
  end

  assign ctl2 = '{query: q2_r, frac: d2_r, l_odd: lodd2_r, r_odd: rodd2_r};

  // ---------------------------------------------------------------- stages 3 to 7
  pmti_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl2),
    .w_lo    (row_cfg.w_lo),
    .w_hi    (row_cfg.w_hi),
    .even_lo (even_lo),
    .even_hi (even_hi),
    .odd_lo  (odd_lo),
    .odd_hi  (odd_hi),
    .res     (res)
  );

  // ---------------------------------------------------------------- result queue
  // pend counts queries accepted and not yet taken; it bounds the queue fill
  assign push      = res.push;
  assign out_valid = (fcnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (pend_r == FIFO_FULL);

  assign out_active_out    = act_q[rd_ptr_r];
  assign out_generated_out = gen_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      act_q[wr_ptr_r] <= res.active;
      gen_q[wr_ptr_r] <= res.generated;
    end
  end

  always_comb begin
    fcnt_nxt = fcnt_r;
    if (push && !pop) begin
      fcnt_nxt = fcnt_r + pmti_pkg::FIFO_CNT_W'(1);
    end else if (!push && pop) begin
      fcnt_nxt = fcnt_r - pmti_pkg::FIFO_CNT_W'(1);
    end
    pend_nxt = pend_r;
    if (q_acc && !pop) begin
      pend_nxt = pend_r + pmti_pkg::FIFO_CNT_W'(1);
    end else if (!q_acc && pop) begin
      pend_nxt = pend_r - pmti_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
      pend_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + pmti_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + pmti_pkg::FIFO_PTR_W'(1);
      end
      fcnt_r <= fcnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  // ---------------------------------------------------------------- checks
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= FIFO_FULL)
    else $error("outstanding query count above queue depth");

  a_fill_le_pend: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= pend_r)
    else $error("queue holds more words than queries outstanding");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (fcnt_r != FIFO_FULL) || pop)
    else $error("result pushed into a full queue");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && !pop) |=> in_stall)
    else $error("input stall released without a result taken");

endmodule

### sim/pmti_mixture_checker.sv
// checker for the poisson mixture table interpolator: watches the channels, predicts and compares words
`timescale 1ns / 1ps

module pmti_mixture_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [pmti_pkg::OP_W-1:0]       in_operation,
  input  logic [pmti_pkg::TROW_W-1:0]     in_table_row,
  input  logic [pmti_pkg::TCOL_W-1:0]     in_table_column,
  input  logic [pmti_pkg::CDF_W-1:0]      in_cdf_value,
  input  logic [pmti_pkg::INT_W-1:0]      in_integrated_value,
  input  logic [pmti_pkg::INTENS_W-1:0]   in_intensity,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [pmti_pkg::ACT_W-1:0]      out_active_out,
  input  logic [pmti_pkg::GEN_W-1:0]      out_generated_out,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [pmti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmti_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_words
);

  import pmti_pkg::*;

  typedef struct packed {
    logic [ACT_W-1:0] active;
    logic [GEN_W-1:0] generated;
  } mix_result_t;

  localparam int ENTRIES = NUM_LEVELS * TABLE_COLUMNS;

  logic [AMP_W-1:0]   amp_reg;
  logic [ISTEP_W-1:0] istep_reg;
  logic [SCALE_W-1:0] scale_reg;
  logic [CDF_W-1:0]   cdf_tab   [ENTRIES];
  logic [INT_W-1:0]   integ_tab [ENTRIES];
  mix_result_t        expected_mix_q [$];

  // row mixture times bilinear column blend over both tables
  function automatic mix_result_t mix_predict(input logic [INTENS_W-1:0] intens);
    logic [AMP_W-1:0]        amp_c;
    logic [AMP_W-FRAC_W-1:0] lvl;
    logic [CW_W-1:0]         w_lo_raw, w_hi_raw;
    logic [WGT_W-1:0]        w_lo, w_hi;
    int unsigned             row_lo, row_hi, col_l, col_r;
    logic [X_W-1:0]          x;
    logic [FRAC_W-1:0]       d;
    logic [CW_W-1:0]         dc;
    logic [63:0]             lx, ly, rx, ry, act, gen;
    mix_result_t             res;
    amp_c = (amp_reg > AMP_W'(NUM_LEVELS << FRAC_W)) ? AMP_W'(NUM_LEVELS << FRAC_W) : amp_reg;
    lvl = amp_c[AMP_W-1:FRAC_W];
    w_hi_raw = CW_W'(amp_c[FRAC_W-1:0]);
    w_lo_raw = CW_W'(1 << FRAC_W) - w_hi_raw;
    if (lvl == 0) begin
      row_lo = 0;
      row_hi = 0;
      w_lo_raw = '0;
    end else begin
      row_lo = lvl - 1;
      row_hi = lvl;
    end
    // top level: upper row folds onto the lower one
    if (lvl == NUM_LEVELS) begin
      row_hi = row_lo;
      w_hi_raw = w_lo_raw;
      w_lo_raw = '0;
    end
    w_lo = WGT_W'((64'(w_lo_raw) * 64'(scale_reg)) >> FRAC_W);
    w_hi = WGT_W'((64'(w_hi_raw) * 64'(scale_reg)) >> FRAC_W);

    x = X_W'(intens) * X_W'(istep_reg);
    col_l = ((x >> XCOL_LSB) > (TABLE_COLUMNS - 1)) ? TABLE_COLUMNS - 1
                                                    : int'(x >> XCOL_LSB);
    col_r = ((x >> XCOL_LSB) >= (TABLE_COLUMNS - 1)) ? TABLE_COLUMNS - 1 : col_l + 1;
    d  = x[XCOL_LSB-1:XCOL_LSB-FRAC_W];
    dc = CW_W'(1 << FRAC_W) - CW_W'(d);

    lx = 64'(dc) * 64'(w_lo);
    ly = 64'(dc) * 64'(w_hi);
    rx = 64'(d) * 64'(w_lo);
    ry = 64'(d) * 64'(w_hi);

    act = lx * 64'(cdf_tab[row_lo * TABLE_COLUMNS + col_l])
        + ly * 64'(cdf_tab[row_hi * TABLE_COLUMNS + col_l])
        + rx * 64'(cdf_tab[row_lo * TABLE_COLUMNS + col_r])
        + ry * 64'(cdf_tab[row_hi * TABLE_COLUMNS + col_r]);
    gen = lx * 64'(integ_tab[row_lo * TABLE_COLUMNS + col_l])
        + ly * 64'(integ_tab[row_hi * TABLE_COLUMNS + col_l])
        + rx * 64'(integ_tab[row_lo * TABLE_COLUMNS + col_r])
        + ry * 64'(integ_tab[row_hi * TABLE_COLUMNS + col_r]);

    res.active    = ((act >> RES_SHIFT) > 64'(ACT_MAX)) ? ACT_MAX : ACT_W'(act >> RES_SHIFT);
    res.generated = ((gen >> RES_SHIFT) > 64'(GEN_MAX)) ? GEN_MAX : GEN_W'(gen >> RES_SHIFT);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    mix_result_t want;
    if (!rst_n) begin
      amp_reg    = AMP_RST;
      istep_reg  = ISTEP_RST;
      scale_reg  = SCALE_RST;
      fail_count = 0;
      expected_mix_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_AMPLITUDE:     amp_reg   = cfg_data[AMP_W-1:0];
          CFG_INVERSE_STEP:  istep_reg = cfg_data[ISTEP_W-1:0];
          CFG_MIXTURE_SCALE: scale_reg = cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (op_t'(in_operation) == OP_QUERY) begin
          expected_mix_q.push_back(mix_predict(in_intensity));
        end else if (in_table_row < NUM_LEVELS) begin
          cdf_tab[in_table_row * TABLE_COLUMNS + in_table_column]   = in_cdf_value;
          integ_tab[in_table_row * TABLE_COLUMNS + in_table_column] = in_integrated_value;
        end
      end

      if (out_valid && !out_stall) begin
        if (expected_mix_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, active_out %0d generated_out %0d",
                   $time, out_active_out, out_generated_out);
        end else begin
          want = expected_mix_q.pop_front();
          if (out_active_out !== want.active) begin
            fail_count++;
            $display("%0t: active_out expected %0d actual %0d",
                     $time, want.active, out_active_out);
          end
          if (out_generated_out !== want.generated) begin
            fail_count++;
            $display("%0t: generated_out expected %0d actual %0d",
                     $time, want.generated, out_generated_out);
          end
        end
      end
    end
    pending_words = expected_mix_q.size();
  end

endmodule

### sim/tb_poisson_mixture_table_interpolator.sv
// testbench top: clock, reset, load/query stimulus, register phases and the verdict
`timescale 1ns / 1ps

module tb_poisson_mixture_table_interpolator;

  import pmti_pkg::*;

  // generous bound: every word waiting out the longest gaps and stalls, several times over
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 12;
  localparam int PHASE_WORDS  = 95;
  localparam int CDF_TOP      = (1 << CDF_W) - 1;
  localparam int AMP_CLAMP    = NUM_LEVELS << FRAC_W;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [OP_W-1:0]       in_operation;
  logic [TROW_W-1:0]     in_table_row;
  logic [TCOL_W-1:0]     in_table_column;
  logic [CDF_W-1:0]      in_cdf_value;
  logic [INT_W-1:0]      in_integrated_value;
  logic [INTENS_W-1:0]   in_intensity;
  logic                  out_valid;
  logic                  out_stall;
  logic [ACT_W-1:0]      out_active_out;
  logic [GEN_W-1:0]      out_generated_out;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending_words;
  int cycle_count = 0;
  int words_sent  = 0;

  // register values as last written, needed to know which entries a query reads
  logic [AMP_W-1:0]   amp_now   = AMP_RST;
  logic [ISTEP_W-1:0] istep_now = ISTEP_RST;

  // entries loaded so far; a query never reads one that is still unwritten
  bit written [NUM_LEVELS][TABLE_COLUMNS];

  // idle shaping: each side alternates between back-to-back stretches and random gaps
  bit in_burst  = 1'b0;
  bit out_burst = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  poisson_mixture_table_interpolator DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_table_row        (in_table_row),
    .in_table_column     (in_table_column),
    .in_cdf_value        (in_cdf_value),
    .in_integrated_value (in_integrated_value),
    .in_intensity        (in_intensity),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_active_out      (out_active_out),
    .out_generated_out   (out_generated_out),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  pmti_mixture_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_table_row        (in_table_row),
    .in_table_column     (in_table_column),
    .in_cdf_value        (in_cdf_value),
    .in_integrated_value (in_integrated_value),
    .in_intensity        (in_intensity),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_active_out      (out_active_out),
    .out_generated_out   (out_generated_out),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending_words       (pending_words)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stall before every word, sometimes long stretches with none
  initial begin
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      // word taken at the first edge with out_valid high while not stalled
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // one input word: optional gap with valid low, then hold it until accepted;
  // called and returns at a falling edge, valid stays high for a following word
  task automatic push_word(input op_t op, input int unsigned row, input int unsigned col,
                           input int unsigned cdf, input int unsigned integ,
                           input logic [INTENS_W-1:0] intens);
    int gap;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= op;
    in_table_row        <= TROW_W'(row);
    in_table_column     <= TCOL_W'(col);
    in_cdf_value        <= CDF_W'(cdf);
    in_integrated_value <= INT_W'(integ);
    in_intensity        <= intens;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    // dropped loads do not count toward the word budget
    if (op == OP_QUERY) begin
      words_sent++;
    end else if (row < NUM_LEVELS) begin
      written[row][col] = 1'b1;
      words_sent++;
    end
  endtask

  // load with explicit values; unused query field gets random bits
  task automatic load_value(input int unsigned row, input int unsigned col,
                            input int unsigned cdf, input int unsigned integ);
    push_word(OP_LOAD, row, col, cdf, integ, $urandom);
  endtask

  // load with random content, extremes now and then
  task automatic load_entry(input int unsigned row, input int unsigned col);
    int unsigned cdf;
    int unsigned integ;
    case ($urandom_range(0, 7))
      0:       cdf = 0;
      1:       cdf = 1 << FRAC_W;
      2:       cdf = CDF_TOP;
      default: cdf = $urandom_range(0, CDF_TOP);
    endcase
    case ($urandom_range(0, 7))
      0:       integ = 0;
      1:       integ = (1 << INT_W) - 1;
      default: integ = $urandom_range(0, (1 << INT_W) - 1);
    endcase
    load_value(row, col, cdf, integ);
  endtask

  // make sure an entry holds data before a query reads it; sometimes reload it
  // right before the query to hit the load-then-read ordering
  task automatic make_ready(input int unsigned row, input int unsigned col);
    if (!written[row][col] || $urandom_range(0, 9) == 0) load_entry(row, col);
  endtask

  // query word with random garbage in the load fields, preceded by whatever
  // loads its four corners still need
  task automatic query_with_tables(input logic [INTENS_W-1:0] intens);
    logic [AMP_W-1:0] amp_c;
    logic [X_W-1:0]   x;
    int unsigned      lvl, row_lo, row_hi, col_l, col_r;
    amp_c  = (amp_now > AMP_W'(AMP_CLAMP)) ? AMP_W'(AMP_CLAMP) : amp_now;
    lvl    = amp_c >> FRAC_W;
    row_lo = (lvl == 0) ? 0 : lvl - 1;
    row_hi = (lvl == 0 || lvl == NUM_LEVELS) ? row_lo : lvl;
    x      = X_W'(intens) * X_W'(istep_now);
    col_l  = ((x >> XCOL_LSB) > (TABLE_COLUMNS - 1)) ? TABLE_COLUMNS - 1 : int'(x >> XCOL_LSB);
    col_r  = (col_l + 1 > TABLE_COLUMNS - 1) ? TABLE_COLUMNS - 1 : col_l + 1;
    make_ready(row_lo, col_l);
    make_ready(row_hi, col_l);
    make_ready(row_lo, col_r);
    make_ready(row_hi, col_r);
    push_word(OP_QUERY, $urandom_range(0, 15), $urandom_range(0, TABLE_COLUMNS - 1),
              $urandom_range(0, CDF_TOP), $urandom_range(0, (1 << INT_W) - 1), intens);
  endtask

  // intensity spread: low window (entries get reused), whole table, top edge,
  // and raw 32-bit values that mostly land beyond the table
  function automatic logic [INTENS_W-1:0] pick_intensity();
    int          kind;
    logic [63:0] lo;
    logic [63:0] hi;
    kind = $urandom_range(0, 99);
    if (istep_now == 0 || kind < 15) return $urandom;
    lo = 0;
    if (kind < 40) begin
      hi = (64'd8 << XCOL_LSB) / istep_now;
    end else if (kind < 85) begin
      hi = (64'(TABLE_COLUMNS) << XCOL_LSB) / istep_now;
    end else begin
      lo = (64'(TABLE_COLUMNS - 2) << XCOL_LSB) / istep_now;
      hi = (64'(TABLE_COLUMNS + 2) << XCOL_LSB) / istep_now;
    end
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    if (lo > hi) lo = hi;
    return $urandom_range(32'(lo), 32'(hi));
  endfunction

  // mostly query sequences with random content, the rest loads and dropped loads
  task automatic random_sequence();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      query_with_tables(pick_intensity());
    end else if (pick < 90) begin
      load_entry($urandom_range(0, NUM_LEVELS - 1), $urandom_range(0, TABLE_COLUMNS - 1));
    end else begin
      // row outside the table: the block must drop it
      push_word(OP_LOAD, $urandom_range(NUM_LEVELS, 15), $urandom_range(0, TABLE_COLUMNS - 1),
                $urandom_range(0, CDF_TOP), $urandom_range(0, (1 << INT_W) - 1), $urandom);
    end
  endtask

  // stop sending, let every expected word come back, then give loads in flight time to land
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  // one register write; valid stays high for a following write
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // idle the block, write all three registers, then run random words
  task automatic run_phase(input logic [AMP_W-1:0] amp, input logic [ISTEP_W-1:0] istep,
                           input logic [SCALE_W-1:0] scale, input int count);
    int start;
    settle();
    write_reg(CFG_AMPLITUDE, CFG_DATA_W'(amp));
    write_reg(CFG_INVERSE_STEP, CFG_DATA_W'(istep));
    write_reg(CFG_MIXTURE_SCALE, CFG_DATA_W'(scale));
    cfg_valid <= 1'b0;
    amp_now   = amp;
    istep_now = istep;
    start = words_sent;
    while (words_sent - start < count) random_sequence();
  endtask

  // directed words under the reset register values (rows 0 and 1, inverse step 5120)
  task automatic directed_words();
    // field extremes on the corners of columns 0 and 1
    load_value(0, 0, 0, 0);
    load_value(1, 0, CDF_TOP, (1 << INT_W) - 1);
    load_value(0, 1, 1 << FRAC_W, 24'h123456);
    load_value(1, 1, 1, 1);
    query_with_tables(32'd0);
    // half a column: fraction in the middle
    query_with_tables(32'd1638);
    // rows beyond the table are dropped, including the largest row field
    load_value(15, 5, CDF_TOP, (1 << INT_W) - 1);
    load_value(NUM_LEVELS, TABLE_COLUMNS - 1, 0, 0);
    // last column and intensity far beyond the table
    load_value(0, TABLE_COLUMNS - 1, CDF_TOP, (1 << INT_W) - 1);
    load_value(1, TABLE_COLUMNS - 1, CDF_TOP, (1 << INT_W) - 1);
    query_with_tables(32'hFFFF_FFFF);
    // exactly on the last column, then one column short of it
    query_with_tables(32'd3352167);
    query_with_tables(32'd3348890);
    // overwrite an entry, then query it
    load_value(0, 0, CDF_TOP, (1 << INT_W) - 1);
    query_with_tables(32'd0);
    // last valid row, both ends
    load_value(NUM_LEVELS - 1, 0, 1 << FRAC_W, 24'hABCDEF);
    load_value(NUM_LEVELS - 1, TABLE_COLUMNS - 1, 0, 24'h000001);
    query_with_tables(32'd100);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_operation        = OP_LOAD;
    in_table_row        = '0;
    in_table_column     = '0;
    in_cdf_value        = '0;
    in_integrated_value = '0;
    in_intensity        = '0;
    cfg_valid           = 1'b0;
    cfg_index           = CFG_AMPLITUDE;
    cfg_data            = '0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_words();

    // amplitude below one, only row 0 with the fractional weight
    run_phase(AMP_W'(32768), ISTEP_RST, SCALE_RST, PHASE_WORDS);
    // amplitude at the top level, largest inverse step and scale
    run_phase(AMP_W'(AMP_CLAMP), '1, '1, PHASE_WORDS);
    // amplitude far above the levels, smallest inverse step, zero scale
    run_phase('1, ISTEP_W'(1), '0, PHASE_WORDS);
    // zero amplitude and zero inverse step: column 0, fraction 0
    run_phase('0, '0, SCALE_RST, PHASE_WORDS);
    // random settings, some with a whole-number amplitude
    repeat (4) begin
      logic [AMP_W-1:0] amp;
      case ($urandom_range(0, 3))
        0:       amp = AMP_W'($urandom_range(0, NUM_LEVELS) << FRAC_W);
        1:       amp = $urandom_range(0, (1 << AMP_W) - 1);
        default: amp = $urandom_range(0, AMP_CLAMP);
      endcase
      run_phase(amp, $urandom_range(1, (1 << ISTEP_W) - 1),
                $urandom_range(0, (1 << SCALE_W) - 1), PHASE_WORDS);
    end

    settle();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/pmti_pkg.sv
rtl/core/pmti_ram.sv
rtl/core/pmti_rowsel.sv
rtl/core/pmti_mac.sv
rtl/core/poisson_mixture_table_interpolator.sv
sim/pmti_mixture_checker.sv
sim/tb_poisson_mixture_table_interpolator.sv
